[rtl/rjp_pkg.sv]
package rjp_pkg;

  localparam int unsigned MAX_FRAGMENT = 1438;
  localparam int unsigned FRAG_W       = $clog2(MAX_FRAGMENT + 1);
  localparam int unsigned OFFSET_W     = 24;
  localparam int unsigned CFG_INDEX_W  = 2;

  localparam logic [15:0] HDR_BYTES        = 16'd20;
  localparam logic [7:0]  PREFIX_MAGIC     = 8'h24;
  localparam logic [7:0]  RTP_VERSION_BYTE = 8'h80;
  localparam logic [7:0]  PAYLOAD_TYPE     = 8'h1A;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CHANNEL_ID = 2'd0,
    CFG_SOURCE_ID  = 2'd1
  } cfg_reg_e;

  typedef enum logic [4:0] {
    POS_MAGIC, POS_CHANNEL, POS_LEN_HI, POS_LEN_LO,
    POS_VERSION, POS_PTYPE, POS_SEQ_HI, POS_SEQ_LO,
    POS_TS3, POS_TS2, POS_TS1, POS_TS0,
    POS_SSRC3, POS_SSRC2, POS_SSRC1, POS_SSRC0,
    POS_TSPEC, POS_OFF2, POS_OFF1, POS_OFF0,
    POS_JTYPE, POS_QUALITY, POS_WIDTH, POS_HEIGHT,
    POS_PAYLOAD
  } hdr_pos_e;

  typedef struct packed {
    logic [7:0]          payload_byte;
    logic [OFFSET_W-1:0] frame_length;
    logic [7:0]          quality;
    logic [10:0]         width;
    logic [10:0]         height;
    logic [31:0]         timestamp;
    logic                interleaved;
  } in_item_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       packet_end;
    logic       frame_end;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic                marker;
    logic [15:0]         total;
    logic [15:0]         seq;
    logic [31:0]         timestamp;
    logic [OFFSET_W-1:0] offset;
    logic [7:0]          quality;
    logic [7:0]          width_units;
    logic [7:0]          height_units;
  } hdr_info_t;

endpackage

[rtl/rjp_header.sv]
module rjp_header import rjp_pkg::*; (
  input  hdr_info_t  hdr_i,
  input  hdr_pos_e   pos_i,
  input  logic [7:0] channel_i,
  input  logic [31:0] source_i,
  input  logic [7:0] payload_i,
  output logic [7:0] byte_o
);

  always_comb begin
    unique case (pos_i)
      POS_MAGIC:   byte_o = PREFIX_MAGIC;
      POS_CHANNEL: byte_o = channel_i;
      POS_LEN_HI:  byte_o = hdr_i.total[15:8];
      POS_LEN_LO:  byte_o = hdr_i.total[7:0];
      POS_VERSION: byte_o = RTP_VERSION_BYTE;
      POS_PTYPE:   byte_o = PAYLOAD_TYPE | {hdr_i.marker, 7'd0};
      POS_SEQ_HI:  byte_o = hdr_i.seq[15:8];
      POS_SEQ_LO:  byte_o = hdr_i.seq[7:0];
      POS_TS3:     byte_o = hdr_i.timestamp[31:24];
      POS_TS2:     byte_o = hdr_i.timestamp[23:16];
      POS_TS1:     byte_o = hdr_i.timestamp[15:8];
      POS_TS0:     byte_o = hdr_i.timestamp[7:0];
      POS_SSRC3:   byte_o = source_i[31:24];
      POS_SSRC2:   byte_o = source_i[23:16];
      POS_SSRC1:   byte_o = source_i[15:8];
      POS_SSRC0:   byte_o = source_i[7:0];
      POS_TSPEC:   byte_o = 8'd0;
      POS_OFF2:    byte_o = hdr_i.offset[23:16];
      POS_OFF1:    byte_o = hdr_i.offset[15:8];
      POS_OFF0:    byte_o = hdr_i.offset[7:0];
      POS_JTYPE:   byte_o = 8'd0;
      POS_QUALITY: byte_o = hdr_i.quality;
      POS_WIDTH:   byte_o = hdr_i.width_units;
      POS_HEIGHT:  byte_o = hdr_i.height_units;
      POS_PAYLOAD: byte_o = payload_i;
      default:     byte_o = 8'd0;
    endcase
  end

endmodule

[rtl/rtp_jpeg_packetizer.sv]
// RTP/JPEG packetizer: each accepted transaction carries one JPEG frame byte and produces
// one output transaction per packet byte, with run_last marking the last one it caused.
// Payload inside a fragment streams at one byte per cycle while out_ready_i is high.
// A byte that opens a fragment first sends its header, 20 bytes (24 with interleaving),
// through the single output register at one byte per cycle while out_ready_i is high,
// and the next input is accepted in the cycle its last byte leaves.
// Frame fields are sampled on the frame's first byte, and the configuration registers
// are read as each header goes out.
module rtp_jpeg_packetizer import rjp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  in_item_t               in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output out_item_t              out_data_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [31:0]            cfg_data_i
);

  logic [7:0]          channel_q;
  logic [31:0]         source_q;
  logic [OFFSET_W-1:0] frame_offset_q;
  logic [FRAG_W-1:0]   fragment_count_q;
  logic [FRAG_W-1:0]   fragment_size_q;
  logic [15:0]         sequence_q;
  logic [OFFSET_W-1:0] latched_length_q;
  logic [7:0]          latched_quality_q;
  logic [7:0]          latched_width_q;
  logic [7:0]          latched_height_q;
  logic [31:0]         latched_timestamp_q;
  logic                latched_interleave_q;

  logic                hold_valid_q;
  hdr_pos_e            hold_pos_q;
  hdr_info_t           hold_hdr_q;
  logic [7:0]          hold_byte_q;
  logic                hold_pend_q;
  logic                hold_fend_q;

  logic                out_valid_q;
  out_item_t           out_q;

  logic                in_accept;
  logic                advance;
  logic                hold_last;
  logic                first;
  logic [OFFSET_W-1:0] len;
  logic [OFFSET_W-1:0] remain;
  logic                fits;
  logic [FRAG_W-1:0]   fsize;
  logic [FRAG_W-1:0]   fcount;
  logic [FRAG_W-1:0]   fcount_inc;
  logic                frag_start;
  logic [FRAG_W-1:0]   cur_size;
  logic                pend;
  logic                fend;
  logic                eff_interleave;
  hdr_info_t           hdr_d;
  logic [7:0]          sel_byte;

  assign cfg_ready_o = 1'b1;

  assign hold_last  = hold_pos_q == POS_PAYLOAD;
  assign advance    = hold_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !hold_valid_q || (advance && hold_last);
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    first = frame_offset_q == '0;
    if (first) begin
      len = (in_data_i.frame_length == '0) ? OFFSET_W'(1) : in_data_i.frame_length;
    end else begin
      len = latched_length_q;
    end
    remain     = len - frame_offset_q;
    fits       = remain <= OFFSET_W'(MAX_FRAGMENT);
    fsize      = fits ? remain[FRAG_W-1:0] : FRAG_W'(MAX_FRAGMENT);
    fcount     = first ? '0 : fragment_count_q;
    fcount_inc = fcount + FRAG_W'(1);
    frag_start = fcount == '0;
    cur_size   = frag_start ? fsize : fragment_size_q;
    pend       = fcount_inc >= cur_size;
    fend       = (frame_offset_q + OFFSET_W'(1)) >= len;
    eff_interleave = first ? in_data_i.interleaved : latched_interleave_q;

    hdr_d.marker       = fits;
    hdr_d.total        = 16'(fsize) + HDR_BYTES;
    hdr_d.seq          = sequence_q;
    hdr_d.offset       = frame_offset_q;
    hdr_d.timestamp    = first ? in_data_i.timestamp : latched_timestamp_q;
    hdr_d.quality      = first ? in_data_i.quality : latched_quality_q;
    hdr_d.width_units  = first ? in_data_i.width[10:3] : latched_width_q;
    hdr_d.height_units = first ? in_data_i.height[10:3] : latched_height_q;
  end

  rjp_header u_header (
    .hdr_i     (hold_hdr_q),
    .pos_i     (hold_pos_q),
    .channel_i (channel_q),
    .source_i  (source_q),
    .payload_i (hold_byte_q),
    .byte_o    (sel_byte)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_q        <= '0;
      source_q         <= '0;
      frame_offset_q   <= '0;
      fragment_count_q <= '0;
      fragment_size_q  <= '0;
      sequence_q       <= '0;
      hold_valid_q     <= 1'b0;
      hold_pos_q       <= POS_PAYLOAD;
      out_valid_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_CHANNEL_ID: channel_q <= cfg_data_i[7:0];
          CFG_SOURCE_ID:  source_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_accept) begin
        hold_valid_q     <= 1'b1;
        hold_pos_q       <= frag_start ? (eff_interleave ? POS_MAGIC : POS_VERSION)
                                       : POS_PAYLOAD;
        fragment_count_q <= pend ? '0 : fcount_inc;
        sequence_q       <= pend ? sequence_q + 16'd1 : sequence_q;
        frame_offset_q   <= fend ? '0 : frame_offset_q + OFFSET_W'(1);
        if (frag_start) begin
          fragment_size_q <= cur_size;
        end
      end else if (advance) begin
        if (hold_last) begin
          hold_valid_q <= 1'b0;
        end else begin
          hold_pos_q <= hdr_pos_e'(hold_pos_q + 5'd1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      hold_hdr_q  <= hdr_d;
      hold_byte_q <= in_data_i.payload_byte;
      hold_pend_q <= pend;
      hold_fend_q <= fend;
      if (first) begin
        latched_length_q     <= len;
        latched_quality_q    <= in_data_i.quality;
        latched_width_q      <= in_data_i.width[10:3];
        latched_height_q     <= in_data_i.height[10:3];
        latched_timestamp_q  <= in_data_i.timestamp;
        latched_interleave_q <= in_data_i.interleaved;
      end
    end
    if (advance) begin
      out_q.packet_byte <= sel_byte;
      out_q.packet_end  <= hold_last && hold_pend_q;
      out_q.frame_end   <= hold_last && hold_fend_q;
      out_q.run_last    <= hold_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_header_no_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.run_last |-> !out_data_o.packet_end && !out_data_o.frame_end)
    else $error("Header byte carries an end flag.");

  a_frame_end_packet_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_end |-> out_data_o.packet_end)
    else $error("Frame ended inside a packet.");

  a_ready_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !hold_valid_q || hold_last)
    else $error("Input accepted while a header is still being sent.");

  a_fragment_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fragment_count_q < FRAG_W'(MAX_FRAGMENT))
    else $error("Fragment count exceeds the fragment limit.");

  a_offset_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_offset_q != '0 |-> frame_offset_q < latched_length_q)
    else $error("Frame offset runs past the frame length.");

endmodule

[dv/tb_rtp_jpeg_packetizer.sv]
`timescale 1ns / 100ps

module tb_rtp_jpeg_packetizer;
  import rjp_pkg::*;

  localparam int unsigned             IDLE_LIMIT = 4000;
  localparam int unsigned             HOLD_CYCLES = 300;
  localparam int unsigned             MAX_SHOWN = 20;
  localparam logic [7:0]              MARKER_BIT = 8'h80;
  localparam logic [CFG_INDEX_W-1:0]  CFG_NO_REG = 2'd3;

  typedef struct packed {
    logic                   cfg_en;
    logic [CFG_INDEX_W-1:0] cfg_idx;
    logic [31:0]            cfg_val;
    logic [23:0]            len;
    logic [7:0]             qual;
    logic [10:0]            wid;
    logic [10:0]            hgt;
    logic [31:0]            ts;
    logic                   ilv;
    logic [7:0]             first;
    logic [15:0]            exp_bytes;
  } frame_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_CHANNEL_ID;
  logic [31:0]            cfg_data = '0;

  out_item_t  pkt_expect_q[$];
  int         frame_total_q[$];
  int         errors = 0;
  int         bytes_in = 0;
  int         bytes_out = 0;
  int         frames_sent = 0;
  int         reg_writes = 0;
  int         frame_bytes_seen = 0;
  int         idle_cycles = 0;
  bit         steady = 1'b0;

  // Predictor state.
  logic [23:0] pos_in_frame = '0;
  logic [10:0] frag_fill = '0;
  logic [10:0] frag_len = '0;
  logic [15:0] seq_nr = '0;
  logic [23:0] f_len = '0;
  logic [7:0]  f_qual = '0;
  logic [7:0]  f_wu = '0;
  logic [7:0]  f_hu = '0;
  logic [31:0] f_ts = '0;
  logic        f_ilv = 1'b0;
  logic [7:0]  chan_reg = '0;
  logic [31:0] ssrc_reg = '0;

  frame_row_t dir_rows [7] = '{
    '{1'b0, CFG_CHANNEL_ID, 32'h0000_0000, 24'd0, 8'h00, 11'd0, 11'd0,
      32'h0000_0000, 1'b0, 8'h00, 16'd21},
    '{1'b1, CFG_CHANNEL_ID, 32'h0000_00FF, 24'd1, 8'hFF, 11'd2047, 11'd2047,
      32'hFFFF_FFFF, 1'b1, 8'hFF, 16'd25},
    '{1'b1, CFG_SOURCE_ID, 32'hFFFF_FFFF, 24'd3, 8'h5A, 11'd640, 11'd480,
      32'h1234_5678, 1'b0, 8'hD8, 16'd23},
    '{1'b1, CFG_NO_REG, 32'hFFFF_FFFF, 24'd2, 8'h01, 11'd7, 11'd8,
      32'h8000_0001, 1'b1, 8'hFF, 16'd26},
    '{1'b1, CFG_CHANNEL_ID, 32'h0000_0000, 24'd4, 8'h80, 11'd1024, 11'd1023,
      32'h0000_FFFF, 1'b1, 8'h00, 16'd28},
    '{1'b1, CFG_SOURCE_ID, 32'h0000_0000, 24'd5, 8'h40, 11'd2040, 11'd16,
      32'hFFFF_0000, 1'b0, 8'hAA, 16'd25},
    '{1'b1, CFG_SOURCE_ID, 32'hA5A5_5A5A, 24'd1, 8'h7F, 11'd320, 11'd240,
      32'hDEAD_BEEF, 1'b1, 8'h55, 16'd25}
  };

  rtp_jpeg_packetizer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void push_hdr(input logic [7:0] b);
    out_item_t r;
    r.packet_byte = b;
    r.packet_end  = 1'b0;
    r.frame_end   = 1'b0;
    r.run_last    = 1'b0;
    pkt_expect_q.push_back(r);
  endfunction

  function automatic void packetize(input in_item_t it);
    logic [23:0] remain;
    logic [15:0] total;
    logic        marker;
    logic        pend;
    logic        fend;
    out_item_t   r;
    if (pos_in_frame == 0) begin
      f_len  = (it.frame_length == 0) ? 24'd1 : it.frame_length;
      f_qual = it.quality;
      f_wu   = it.width[10:3];
      f_hu   = it.height[10:3];
      f_ts   = it.timestamp;
      f_ilv  = it.interleaved;
      frag_fill = '0;
    end
    if (frag_fill == 0) begin
      remain   = f_len - pos_in_frame;
      frag_len = (remain > MAX_FRAGMENT) ? 11'(MAX_FRAGMENT) : remain[10:0];
      marker   = ((pos_in_frame + 24'(frag_len)) == f_len);
      total    = 16'(frag_len) + HDR_BYTES;
      if (f_ilv) begin
        push_hdr(PREFIX_MAGIC);
        push_hdr(chan_reg);
        push_hdr(total[15:8]);
        push_hdr(total[7:0]);
      end
      push_hdr(RTP_VERSION_BYTE);
      push_hdr(PAYLOAD_TYPE | (marker ? MARKER_BIT : 8'h00));
      push_hdr(seq_nr[15:8]);
      push_hdr(seq_nr[7:0]);
      push_hdr(f_ts[31:24]);
      push_hdr(f_ts[23:16]);
      push_hdr(f_ts[15:8]);
      push_hdr(f_ts[7:0]);
      push_hdr(ssrc_reg[31:24]);
      push_hdr(ssrc_reg[23:16]);
      push_hdr(ssrc_reg[15:8]);
      push_hdr(ssrc_reg[7:0]);
      push_hdr(8'h00);
      push_hdr(pos_in_frame[23:16]);
      push_hdr(pos_in_frame[15:8]);
      push_hdr(pos_in_frame[7:0]);
      push_hdr(8'h00);
      push_hdr(f_qual);
      push_hdr(f_wu);
      push_hdr(f_hu);
    end
    pend = ({1'b0, frag_fill} + 12'd1) >= {1'b0, frag_len};
    fend = ({1'b0, pos_in_frame} + 25'd1) >= {1'b0, f_len};
    r.packet_byte = it.payload_byte;
    r.packet_end  = pend;
    r.frame_end   = fend;
    r.run_last    = 1'b1;
    pkt_expect_q.push_back(r);
    if (pend) begin
      frag_fill = '0;
      seq_nr    = seq_nr + 16'd1;
    end else begin
      frag_fill = frag_fill + 11'd1;
    end
    pos_in_frame = fend ? 24'd0 : pos_in_frame + 24'd1;
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    gap = (!steady && $urandom_range(0, 99) < 16) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    packetize(it);
    bytes_in++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    in_valid <= 1'b0;
    while (pkt_expect_q.size() != 0) @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_CHANNEL_ID) begin
      chan_reg = val[7:0];
    end else if (idx == CFG_SOURCE_ID) begin
      ssrc_reg = val;
    end
    reg_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic write_random_reg();
    logic [CFG_INDEX_W-1:0] idx;
    logic [31:0]            val;
    case ($urandom_range(0, 9))
      0:       idx = CFG_NO_REG;
      1, 2, 3: idx = CFG_CHANNEL_ID;
      default: idx = CFG_SOURCE_ID;
    endcase
    case ($urandom_range(0, 3))
      0:       val = '0;
      1:       val = '1;
      default: val = $urandom;
    endcase
    write_reg(idx, val);
  endtask

  task automatic send_frame(input logic [23:0] len, input logic [7:0] qual,
                            input logic [10:0] wid, input logic [10:0] hgt,
                            input logic [31:0] ts, input logic ilv,
                            input logic [7:0] first, input int typed_total,
                            input int cfg_at);
    int       nbytes;
    in_item_t it;
    nbytes = (len == 0) ? 1 : int'(len);
    frame_total_q.push_back(typed_total);
    frames_sent++;
    for (int i = 0; i < nbytes; i++) begin
      if (i == cfg_at) write_random_reg();
      if (i == 0) begin
        it.payload_byte = first;
        it.frame_length = len;
        it.quality      = qual;
        it.width        = wid;
        it.height       = hgt;
        it.timestamp    = ts;
        it.interleaved  = ilv;
      end else begin
        it.payload_byte = 8'($urandom);
        it.frame_length = 24'($urandom);
        it.quality      = 8'($urandom);
        it.width        = 11'($urandom);
        it.height       = 11'($urandom);
        it.timestamp    = $urandom;
        it.interleaved  = 1'($urandom);
      end
      send_item(it);
    end
  endtask

  // Consumer side: random back-pressure plus one long hold-off.
  initial begin
    bit held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!held && bytes_out >= 250) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= 16);
      end
    end
  end

  always @(posedge clk) begin : check_output
    out_item_t want;
    int        typed;
    if (rst_n && out_valid && out_ready) begin
      bytes_out++;
      frame_bytes_seen++;
      if (pkt_expect_q.size() == 0) begin
        if (errors < MAX_SHOWN) begin
          $display("%0t: unexpected packet byte %h (pend %b fend %b last %b)", $time,
                   out_data.packet_byte, out_data.packet_end, out_data.frame_end,
                   out_data.run_last);
        end
        errors++;
      end else begin
        want = pkt_expect_q.pop_front();
        if (out_data !== want) begin
          if (errors < MAX_SHOWN) begin
            $display("%0t: expected byte %h ends %b%b last %b, got byte %h ends %b%b last %b",
                     $time, want.packet_byte, want.packet_end, want.frame_end, want.run_last,
                     out_data.packet_byte, out_data.packet_end, out_data.frame_end,
                     out_data.run_last);
          end
          errors++;
        end
      end
      if (out_data.frame_end) begin
        if (frame_total_q.size() != 0) begin
          typed = frame_total_q.pop_front();
          if (typed != 0 && typed != frame_bytes_seen) begin
            if (errors < MAX_SHOWN) begin
              $display("%0t: expected %0d bytes for the frame, got %0d", $time, typed,
                       frame_bytes_seen);
            end
            errors++;
          end
        end
        frame_bytes_seen = 0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d packet bytes still expected",
                 $time, idle_cycles, pkt_expect_q.size());
        $display("tb_rtp_jpeg_packetizer: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int       nbytes;
    int       cfg_at;
    logic [23:0] len;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].cfg_en) write_reg(dir_rows[r].cfg_idx, dir_rows[r].cfg_val);
      send_frame(dir_rows[r].len, dir_rows[r].qual, dir_rows[r].wid, dir_rows[r].hgt,
                 dir_rows[r].ts, dir_rows[r].ilv, dir_rows[r].first,
                 int'(dir_rows[r].exp_bytes), -1);
    end

    for (int f = 0; f < 14; f++) begin
      case (f)
        7:       len = 24'd40;
        default: begin
          case ($urandom_range(0, 9))
            0:       len = 24'd0;
            1:       len = 24'($urandom_range(17, 40));
            default: len = 24'($urandom_range(1, 16));
          endcase
        end
      endcase
      steady = (f == 7);
      nbytes = (len == 0) ? 1 : int'(len);
      cfg_at = (nbytes > 1 && $urandom_range(0, 3) == 0) ? $urandom_range(1, nbytes - 1) : -1;
      if ($urandom_range(0, 3) == 0) write_random_reg();
      send_frame(len, 8'($urandom), 11'($urandom), 11'($urandom), $urandom,
                 1'($urandom), 8'($urandom), 0, cfg_at);
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (pkt_expect_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (pkt_expect_q.size() != 0) begin
      $display("%0t: %0d packet bytes never arrived", $time, pkt_expect_q.size());
      errors++;
    end
    $display("Sent %0d frames (%0d bytes, %0d register writes), checked %0d packet bytes.",
             frames_sent, bytes_in, reg_writes, bytes_out);
    $display("Frames of one to forty bytes, each in one fragment, with and without the prefix.");
    if (errors == 0) begin
      $display("tb_rtp_jpeg_packetizer: done, clean");
    end else begin
      $display("tb_rtp_jpeg_packetizer: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/rjp_pkg.sv
rtl/rjp_header.sv
rtl/rtp_jpeg_packetizer.sv
dv/tb_rtp_jpeg_packetizer.sv
